// ===== hdl/min_max_ten_bin_histogram_macros.svh =====
// Assertion helpers for the histogram block
`ifndef MIN_MAX_TEN_BIN_HISTOGRAM_MACROS_SVH
`define MIN_MAX_TEN_BIN_HISTOGRAM_MACROS_SVH

`define MMH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/mmh_pkg.sv =====
package mmh_pkg;
    localparam int SAMPLE_DEPTH = 4096;
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W = 13;
    localparam int NUM_BINS = 10;
    localparam int BIN_W = 4;
    localparam int PCT_W = 7;
    localparam logic signed [31:0] INVALID_MARK = -32'sd65536;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    // ceil(2^23/10): (x*RECIP10)>>23 is exactly floor(x/10) for x < 2^20
    localparam logic [19:0] RECIP10 = 20'd838861;
    localparam int RECIP10_SH = 23;

    // load request passed from front to back
    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
        logic               drop;
    } t_req;
endpackage

// ===== hdl/mmh_front.sv =====
module mmh_front
    import mmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_sample,
    input  logic               i_last_sample,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output t_req               o_q_data
);
    t_req              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_fill;
    logic [CNT_W-1:0]  r_cnt;
    logic              push;
    t_req              req;

    assign o_stall   = (r_fill == (QPTR_W+1)'(QDEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_fill != '0);
    assign o_q_data  = r_q[r_rd];

    // front tracks store occupancy to classify drops
    always_comb begin
        req.sample = i_sample;
        req.last   = i_last_sample;
        req.drop   = (r_cnt == CNT_W'(SAMPLE_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= req;
        end
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_fill <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
                if (i_last_sample) begin
                    r_cnt <= '0;
                end else if (!req.drop) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_q_pop);
        end
    end
endmodule

// ===== hdl/mmh_back.sv =====
module mmh_back
    import mmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t_req               i_q_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BIN_W-1:0]   o_bin_index,
    output logic signed [31:0] o_lower_edge,
    output logic signed [31:0] o_upper_edge,
    output logic [CNT_W-1:0]   o_bin_count,
    output logic [PCT_W-1:0]   o_percent,
    output logic [CNT_W-1:0]   o_valid_count,
    output logic               o_overflow,
    output logic               o_empty_set,
    output logic               o_last_bin
);
    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_RANGE = 4'd1;
    localparam logic [3:0] S_EDGE = 4'd2;
    localparam logic [3:0] S_RD = 4'd3;
    localparam logic [3:0] S_CMP = 4'd4;
    localparam logic [3:0] S_PCT = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_OUT = 4'd7;
    localparam logic [3:0] S_WAIT = 4'd8;
    localparam logic [3:0] S_RQHI = 4'd9;
    localparam logic [3:0] S_RQLO = 4'd10;

    logic [3:0] r_st;
    logic signed [31:0] r_mem [SAMPLE_DEPTH];
    logic signed [31:0] r_rdata;
    logic [CNT_W-1:0]   r_stored, r_valid, r_j;
    logic signed [32:0] r_max, r_min, r_lo;
    logic [32:0]        r_range;
    logic               r_drop;
    logic [CNT_W-1:0]   r_bins [NUM_BINS];
    // thresholds i*range, i=0..NUM_BINS
    logic [36:0]        r_thr [NUM_BINS+1];
    logic [BIN_W-1:0]   r_i;
    logic signed [31:0] r_edge [NUM_BINS+1];
    // range = 10*r_qa + r_ra; edge offset i*range/10 = r_eq + r_er/10
    logic [32:0]        r_qa, r_eq;
    logic [3:0]         r_ra, r_er;
    logic [36:0]        r_tacc;
    // percent divider: restoring, one quotient bit per cycle
    logic [CNT_W+PCT_W-1:0] r_num;
    logic [CNT_W+PCT_W:0]   r_rem;
    logic [CNT_W+PCT_W-1:0] r_quo;
    logic [4:0]             r_dc;
    logic [CNT_W+PCT_W:0]   rem_sh;
    logic signed [32:0]     x33;
    logic [19:0]            div_x, div_q;
    logic [39:0]            div_p;
    logic [3:0]             div_r;
    logic [4:0]             er_sum;

    assign o_q_pop = (r_st == S_LOAD) && i_q_valid;
    assign x33 = 33'(i_q_data.sample);
    assign rem_sh = {r_rem[CNT_W+PCT_W-1:0], r_num[CNT_W+PCT_W-1]};
    assign er_sum = 5'(r_er) + 5'(r_ra);

    // range/10 in two digits, the 17-bit high digit first, then the 16-bit low one
    always_comb begin
        div_x = (r_st == S_RQHI) ? 20'(r_range[32:16]) : {r_ra, r_range[15:0]};
        div_p = 40'(div_x) * 40'(RECIP10);
        div_q = 20'(div_p >> RECIP10_SH);
        div_r = 4'(div_x - 20'(div_q * 20'd10));
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_data.drop) begin
            r_mem[r_stored[ADDR_W-1:0]] <= i_q_data.sample;
        end
        if (r_st == S_RD) begin
            r_rdata <= r_mem[r_j[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_stored <= '0;
            r_valid <= '0;
            r_max <= '0;
            r_min <= 33'sd2147483647;
            r_drop <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k < NUM_BINS; k++) r_bins[k] <= '0;
        end else begin
            case (r_st)
                S_LOAD: begin
                    if (o_q_pop) begin
                        if (i_q_data.drop) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_stored <= r_stored + 1'b1;
                            if (x33 > r_max) r_max <= x33;
                            if (i_q_data.sample != INVALID_MARK) begin
                                r_valid <= r_valid + 1'b1;
                                if (x33 < r_min) r_min <= x33;
                            end
                        end
                        if (i_q_data.last) r_st <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (r_valid != '0 && r_min < r_max) begin
                        r_lo <= r_min;
                        r_range <= 33'(r_max - r_min);
                    end else begin
                        r_lo <= r_max;
                        r_range <= '0;
                    end
                    r_i <= '0;
                    r_st <= S_RQHI;
                end
                S_RQHI: begin
                    r_qa <= {div_q[16:0], 16'd0};
                    r_ra <= div_r;
                    r_st <= S_RQLO;
                end
                S_RQLO: begin
                    r_qa <= {r_qa[32:16], div_q[15:0]};
                    r_ra <= div_r;
                    r_eq <= '0;
                    r_er <= '0;
                    r_tacc <= '0;
                    r_i <= '0;
                    r_st <= S_EDGE;
                end
                S_EDGE: begin
                    r_thr[r_i] <= r_tacc;
                    r_edge[r_i] <= 32'(34'(r_lo) + 34'(r_eq));
                    r_tacc <= r_tacc + 37'(r_range);
                    if (er_sum >= 5'd10) begin
                        r_eq <= r_eq + r_qa + 33'd1;
                        r_er <= 4'(er_sum - 5'd10);
                    end else begin
                        r_eq <= r_eq + r_qa;
                        r_er <= 4'(er_sum);
                    end
                    if (r_i == BIN_W'(NUM_BINS)) begin
                        r_j <= '0;
                        r_i <= '0;
                        r_st <= (r_stored == '0) ? S_PCT : S_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_RD: begin
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    for (int k = 0; k < NUM_BINS; k++) begin
                        if ((38'(r_rdata) - 38'(r_lo)) * 38'sd10 >= $signed({1'b0, r_thr[k]})
                            && (38'(r_rdata) - 38'(r_lo)) * 38'sd10
                               < $signed({1'b0, r_thr[k+1]})) begin
                            r_bins[k] <= r_bins[k] + 1'b1;
                        end
                    end
                    r_j <= r_j + 1'b1;
                    r_st <= (r_j + 1'b1 == r_stored) ? S_PCT : S_RD;
                    r_i <= '0;
                end
                S_PCT: begin
                    r_num <= (CNT_W+PCT_W)'(r_bins[r_i]) * (CNT_W+PCT_W)'(PCT_FULL)
                             + (CNT_W+PCT_W)'(r_valid) - 1'b1;
                    r_rem <= '0;
                    r_dc <= '0;
                    r_st <= (r_valid == '0) ? S_OUT : S_DIV;
                    r_quo <= '0;
                end
                S_DIV: begin
                    if (rem_sh >= (CNT_W+PCT_W+1)'(r_valid)) begin
                        r_rem <= rem_sh - (CNT_W+PCT_W+1)'(r_valid);
                        r_quo <= {r_quo[CNT_W+PCT_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[CNT_W+PCT_W-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_dc <= r_dc + 1'b1;
                    if (r_dc == 5'(CNT_W+PCT_W-1)) r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_bin_index <= r_i;
                    o_lower_edge <= r_edge[r_i];
                    o_upper_edge <= (r_i == BIN_W'(NUM_BINS-1)) ? 32'(r_max) : r_edge[r_i+1];
                    o_bin_count <= r_bins[r_i];
                    o_percent <= (r_valid == '0) ? '0 :
                                 (r_quo > (CNT_W+PCT_W)'(PCT_FULL)) ? PCT_FULL : PCT_W'(r_quo);
                    o_valid_count <= r_valid;
                    o_overflow <= r_drop;
                    o_empty_set <= (r_valid == '0);
                    o_last_bin <= (r_i == BIN_W'(NUM_BINS-1));
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (r_i == BIN_W'(NUM_BINS-1)) begin
                            r_st <= S_LOAD;
                            r_stored <= '0;
                            r_valid <= '0;
                            r_max <= '0;
                            r_min <= 33'sd2147483647;
                            r_drop <= 1'b0;
                            for (int k = 0; k < NUM_BINS; k++) r_bins[k] <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_st <= S_PCT;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== hdl/min_max_ten_bin_histogram.sv =====
// Ten-bin equal-width histogram over a data set of signed Q16.16 samples.
// Input channel: i_valid/o_stall with i_sample and i_last_sample. A request
// with i_last_sample high closes the data set. -1.0 marks an invalid sample.
// Output channel: o_valid/i_stall; ten results per data set, bin 0 first,
// o_last_bin on the tenth.
// A four-entry queue sits between the front and the loader, so input is
// taken one request per cycle while the loader keeps up. After the last
// request the back end computes the range and bin edges, rereads each
// stored sample from the 4096-entry store (single read port) to bin it,
// then runs the percent divider and output handshake for each bin (no
// divider when the set has no valid samples); output stall holds it.
// Input stalls once the queue fills while the back end works on a set.
// Samples past 4096 are dropped and flag o_overflow.
// Reset (synchronous, active low) empties the queue and clears the set
// statistics; the sample store needs no clearing.
// A stalled result holds until taken.
module min_max_ten_bin_histogram
    import mmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_sample,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_bin_index,
    output logic signed [31:0] o_lower_edge,
    output logic signed [31:0] o_upper_edge,
    output logic [12:0]        o_bin_count,
    output logic [6:0]         o_percent,
    output logic [12:0]        o_valid_count,
    output logic               o_overflow,
    output logic               o_empty_set,
    output logic               o_last_bin
);
`include "min_max_ten_bin_histogram_macros.svh"
    logic q_valid, q_pop;
    t_req q_data;

    mmh_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample, .i_last_sample,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    mmh_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .o_valid, .i_stall, .o_bin_index, .o_lower_edge, .o_upper_edge,
        .o_bin_count, .o_percent, .o_valid_count, .o_overflow, .o_empty_set,
        .o_last_bin
    );

    `MMH_ASSERT_IMPL(a_pop_has_data, i_clk, i_rst_n, q_pop, q_valid)
    `MMH_ASSERT_IMPL(a_pct_range, i_clk, i_rst_n, o_valid, o_percent <= 7'd100)
    `MMH_ASSERT_IMPL(a_empty_pct, i_clk, i_rst_n, o_valid && o_empty_set, o_percent == 7'd0)
    `MMH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_bin_index))
endmodule

// ===== test/min_max_ten_bin_histogram_tb.sv =====
`timescale 1ns / 100ps

module min_max_ten_bin_histogram_tb;
    import mmh_pkg::*;

    typedef struct {
        logic [3:0]         bin_index;
        logic signed [31:0] lower_edge;
        logic signed [31:0] upper_edge;
        logic [12:0]        bin_count;
        logic [6:0]         percent;
        logic [12:0]        valid_count;
        logic               overflow;
        logic               empty_set;
        logic               last_bin;
    } t_bin_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_sample;
    logic               i_last_sample;
    logic               o_valid;
    logic               i_stall;
    logic [3:0]         o_bin_index;
    logic signed [31:0] o_lower_edge;
    logic signed [31:0] o_upper_edge;
    logic [12:0]        o_bin_count;
    logic [6:0]         o_percent;
    logic [12:0]        o_valid_count;
    logic               o_overflow;
    logic               o_empty_set;
    logic               o_last_bin;

    // histogram predictor state
    logic signed [31:0] set_samples[$];
    int unsigned        set_valid;
    longint             set_max;
    longint             set_min;
    bit                 set_dropped;
    t_bin_result        expected_bins[$];
    int                 error_count;
    bit                 hold_off;

    min_max_ten_bin_histogram uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic clear_set();
        set_samples.delete();
        set_valid = 0;
        set_max = 0;
        set_min = 64'sd2147483647;
        set_dropped = 0;
    endtask

    task automatic predict_sample(logic signed [31:0] x, bit last);
        longint lo;
        longint range;
        longint d;
        longint cnt[NUM_BINS];
        longint pct;
        t_bin_result r;
        if (set_samples.size() < SAMPLE_DEPTH) begin
            set_samples.push_back(x);
            if (longint'(x) > set_max) set_max = x;
            if (x != INVALID_MARK) begin
                set_valid++;
                if (longint'(x) < set_min) set_min = x;
            end
        end else begin
            set_dropped = 1;
        end
        if (!last) return;
        lo = (set_valid != 0 && set_min < set_max) ? set_min : set_max;
        range = set_max - lo;
        foreach (cnt[i]) cnt[i] = 0;
        foreach (set_samples[j]) begin
            d = (longint'(set_samples[j]) - lo) * NUM_BINS;
            for (int i = 0; i < NUM_BINS; i++)
                if (d >= i * range && d < (i + 1) * range) cnt[i]++;
        end
        for (int i = 0; i < NUM_BINS; i++) begin
            pct = 0;
            if (set_valid != 0) begin
                pct = (cnt[i] * 100 + set_valid - 1) / set_valid;
                if (pct > 100) pct = 100;
            end
            r.bin_index   = i;
            r.lower_edge  = lo + (i * range) / NUM_BINS;
            r.upper_edge  = (i == NUM_BINS - 1) ? set_max : lo + ((i + 1) * range) / NUM_BINS;
            r.bin_count   = cnt[i];
            r.percent     = pct;
            r.valid_count = set_valid;
            r.overflow    = set_dropped;
            r.empty_set   = (set_valid == 0);
            r.last_bin    = (i == NUM_BINS - 1);
            expected_bins.push_back(r);
        end
        clear_set();
    endtask

    // valid stays high between back-to-back requests
    task automatic send_sample(logic signed [31:0] x, bit last, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= x;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_sample(x, last);
    endtask

    // receiver: random stall per request, long hold-off on demand
    initial begin
        int wait_cycles;
        i_stall = 1'b1;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            wait_cycles = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_bin_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bins.size() == 0) begin
                $error("unexpected result bin_index=%0d", o_bin_index);
                error_count++;
            end else begin
                e = expected_bins.pop_front();
                if (o_bin_index !== e.bin_index) begin
                    $error("bin_index exp %0d got %0d", e.bin_index, o_bin_index);
                    error_count++;
                end
                if (o_lower_edge !== e.lower_edge) begin
                    $error("lower_edge exp %0d got %0d", e.lower_edge, o_lower_edge);
                    error_count++;
                end
                if (o_upper_edge !== e.upper_edge) begin
                    $error("upper_edge exp %0d got %0d", e.upper_edge, o_upper_edge);
                    error_count++;
                end
                if (o_bin_count !== e.bin_count) begin
                    $error("bin_count exp %0d got %0d", e.bin_count, o_bin_count);
                    error_count++;
                end
                if (o_percent !== e.percent) begin
                    $error("percent exp %0d got %0d", e.percent, o_percent);
                    error_count++;
                end
                if (o_valid_count !== e.valid_count) begin
                    $error("valid_count exp %0d got %0d", e.valid_count, o_valid_count);
                    error_count++;
                end
                if (o_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_overflow);
                    error_count++;
                end
                if (o_empty_set !== e.empty_set) begin
                    $error("empty_set exp %0d got %0d", e.empty_set, o_empty_set);
                    error_count++;
                end
                if (o_last_bin !== e.last_bin) begin
                    $error("last_bin exp %0d got %0d", e.last_bin, o_last_bin);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return INVALID_MARK;
            1: return $urandom();
            2: return $signed($urandom_range(0, 20)) << 16;
            3: return -($signed($urandom_range(0, 20)) << 16);
            4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic test_extremes();
        send_sample(32'sh80000000, 0);
        send_sample(32'sh7fffffff, 0);
        send_sample(0, 0);
        send_sample(-1, 0);
        send_sample(INVALID_MARK, 0);
        send_sample(32'sh00010000, 1);
        send_sample(32'sh55555555, 0);
        send_sample(32'shaaaaaaaa, 1);
    endtask

    task automatic test_no_valid();
        send_sample(INVALID_MARK, 0);
        send_sample(INVALID_MARK, 1);
        send_sample(INVALID_MARK, 1);
    endtask

    task automatic test_flat_set();
        send_sample(32'sh00030000, 0);
        send_sample(32'sh00030000, 1);
        send_sample(-5, 0);
        send_sample(-5, 1);
    endtask

    // invalid marks land inside the range so counts exceed valid total
    task automatic test_invalid_in_bin();
        send_sample(-32'sh00020000, 0);
        send_sample(INVALID_MARK, 0);
        send_sample(INVALID_MARK, 0);
        send_sample(32'sh00020000, 1);
    endtask

    task automatic test_random_sets();
        int len;
        for (int n = 0; n < 237; n += len) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                send_sample(rand_sample(), k == len - 1);
        end
    endtask

    // receiver holds off while sets keep coming so the input stalls
    task automatic test_backpressure();
        int len;
        hold_off = 1;
        for (int s = 0; s < 4; s++) begin
            len = $urandom_range(2, 5);
            for (int k = 0; k < len; k++)
                send_sample(rand_sample(), k == len - 1, 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_last_sample = 1'b0;
        error_count = 0;
        hold_off = 0;
        clear_set();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_no_valid();
        test_flat_set();
        test_invalid_in_bin();
        test_backpressure();
        test_random_sets();
        i_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
